### rtl/core/lkvc_pkg.sv
// Shared constants and types for the LRU key-value cache.
package lkvc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Request tdata: lookup_key, write_value.
  localparam int S_TDATA_W = KEY_W + VAL_W;

  // Result tdata: hit, read_value, evicted, evicted_key, zero fill.
  localparam int HIT_BIT   = 0;
  localparam int VAL_LSB   = 1;
  localparam int EVICT_BIT = VAL_LSB + VAL_W;
  localparam int EVKEY_LSB = EVICT_BIT + 1;
  localparam int M_USED_W  = EVKEY_LSB + KEY_W;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_AGE    = 5'b01000,
    ST_RESP   = 5'b10000
  } lkvc_state_t;

endpackage

### rtl/core/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
//
// Requests enter on the s_axis channel: tuser carries the kind (get or put),
// tdata carries the key and the value to store. Each request gives exactly
// one result on the m_axis channel: hit flag, read value, evicted flag and
// evicted key. capacity is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Zero acts as 1 and values above ENTRIES act as ENTRIES.
//
// One request is handled at a time. A single key comparator walks the key
// memory one entry per cycle, the decide state commits the decision, then
// a rank sweep ages the recency ranks one entry per cycle; a get that
// misses skips the rank sweep. s_axis_tready is high only while idle. The
// result waits in an output register; a new request may be accepted while
// it waits, and its own result holds until the register frees. Reset
// clears all valid marks, the fill count and capacity (back to 16); keys,
// values and ranks are not cleared.
module lru_key_value_cache_core #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]      cfg_wr_data,    // capacity
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lkvc_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // lookup_key, write_value
  input  logic                            s_axis_tuser,   // req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lkvc_pkg::M_TDATA_W-1:0]  m_axis_tdata    // hit, read_value, evicted,
                                                          // evicted_key, zero fill
);
  import lkvc_pkg::*;

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW   = IW;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;

  lkvc_state_t state;

  logic [CAP_W-1:0]   capacity;
  logic [ENTRIES-1:0] entry_valid;
  logic [CNTW-1:0]    fill_count;
  logic [CNTW-1:0]    idx;
  logic [IW-1:0]      pidx;
  logic               pvalid;

  // Memories
  logic [KEY_W-1:0] key_mem  [ENTRIES];
  logic [VAL_W-1:0] val_mem  [ENTRIES];
  logic [RW-1:0]    rank_mem [ENTRIES];
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [RW-1:0]    rank_rd;

  // Request and scan results
  logic             req_put;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_val;
  logic             found;
  logic [IW-1:0]    found_idx;
  logic [RW-1:0]    found_rank;
  logic             free;
  logic [IW-1:0]    free_idx;
  logic             any;
  logic [IW-1:0]    best_idx;
  logic [RW-1:0]    best_rank;
  logic [KEY_W-1:0] best_key;

  // Rank sweep controls and result
  logic [IW-1:0]    target;
  logic [RW-1:0]    thr;
  logic             age_all;
  logic             res_hit;
  logic [VAL_W-1:0] res_value;
  logic             use_mem;
  logic             res_evict;
  logic [KEY_W-1:0] res_ev_key;

  logic [IW-1:0]    rd_addr;
  logic             idx_done;
  logic             key_match;
  logic [CMPW-1:0]  cap_ext;
  logic [CMPW-1:0]  eff_cap;
  logic             fill_ok;
  logic             take_free;
  logic             do_evict;
  logic             new_entry;
  logic [IW-1:0]    new_slot;
  logic [RW-1:0]    rank_new;
  logic             out_free;
  logic             s_acc;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign idx_done      = (idx == CNTW'(ENTRIES));
  assign rd_addr       = idx_done ? '0 : idx[IW-1:0];
  assign key_match     = pvalid && entry_valid[pidx] && (key_rd == req_key);

  assign cap_ext = CMPW'(capacity);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign fill_ok   = CMPW'(fill_count) < eff_cap;
  assign take_free = fill_ok && free;
  assign do_evict  = !take_free && any;
  assign new_entry = !do_evict;
  assign new_slot  = take_free ? free_idx : (any ? best_idx : '0);

  always_comb begin
    if (pidx == target) begin
      rank_new = '0;
    end else if (entry_valid[pidx] && (age_all || rank_rd < thr)) begin
      rank_new = rank_rd + RW'(1);
    end else begin
      rank_new = rank_rd;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      capacity      <= CAP_RESET;
      entry_valid   <= '0;
      fill_count    <= '0;
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
      pvalid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      // Load a new result, else hold the waiting one until taken.
      m_axis_tvalid <= ((state == ST_RESP) && out_free) ||
                       (m_axis_tvalid && !m_axis_tready);
      pvalid <= ((state == ST_SCAN) || (state == ST_AGE)) && !idx_done;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (s_acc) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_done) begin
            state <= ST_DECIDE;
          end else begin
            idx <= idx + CNTW'(1);
          end
        end
        ST_DECIDE: begin
          idx <= '0;
          if (req_put && !found && new_entry) begin
            entry_valid[new_slot] <= 1'b1;
            fill_count            <= fill_count + CNTW'(1);
          end
          state <= (!req_put && !found) ? ST_RESP : ST_AGE;
        end
        ST_AGE: begin
          if (idx_done) begin
            state <= ST_RESP;
          end else begin
            idx <= idx + CNTW'(1);
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    pidx <= rd_addr;
    if (s_acc) begin
      req_put <= (s_axis_tuser == REQ_PUT);
      req_key <= s_axis_tdata[KEY_W-1:0];
      req_val <= s_axis_tdata[KEY_W +: VAL_W];
      found   <= 1'b0;
      free    <= 1'b0;
      any     <= 1'b0;
    end
    if (state == ST_SCAN && pvalid) begin
      if (key_match && !found) begin
        found      <= 1'b1;
        found_idx  <= pidx;
        found_rank <= rank_rd;
      end
      if (!entry_valid[pidx] && !free) begin
        free     <= 1'b1;
        free_idx <= pidx;
      end
      if (entry_valid[pidx] && (!any || rank_rd > best_rank)) begin
        any       <= 1'b1;
        best_idx  <= pidx;
        best_rank <= rank_rd;
        best_key  <= key_rd;
      end
    end
    if (state == ST_DECIDE) begin
      if (!req_put) begin
        res_hit    <= found;
        res_value  <= MISS_VALUE;
        use_mem    <= found;
        res_evict  <= 1'b0;
        res_ev_key <= '0;
        target     <= found_idx;
        thr        <= found_rank;
        age_all    <= 1'b0;
      end else if (found) begin
        res_hit    <= 1'b1;
        res_value  <= '0;
        use_mem    <= 1'b0;
        res_evict  <= 1'b0;
        res_ev_key <= '0;
        target     <= found_idx;
        thr        <= found_rank;
        age_all    <= 1'b0;
      end else begin
        res_hit    <= 1'b0;
        res_value  <= '0;
        use_mem    <= 1'b0;
        res_evict  <= do_evict;
        res_ev_key <= do_evict ? best_key : '0;
        target     <= new_slot;
        age_all    <= 1'b1;
      end
    end
    if (state == ST_RESP && out_free) begin
      m_axis_tdata <= M_TDATA_W'({res_ev_key, res_evict,
                                  (use_mem ? val_rd : res_value), res_hit});
    end
  end

  // Key, value and rank memories
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && req_put) begin
      if (found) begin
        val_mem[found_idx] <= req_val;
      end else begin
        val_mem[new_slot] <= req_val;
        key_mem[new_slot] <= req_key;
      end
    end
    if (state == ST_AGE && pvalid) begin
      rank_mem[pidx] <= rank_new;
    end
    key_rd  <= key_mem[rd_addr];
    rank_rd <= rank_mem[rd_addr];
    val_rd  <= val_mem[found_idx];
  end

endmodule

### rtl/core/lkvc_checker.sv
// Port-level checks for the LRU key-value cache, bound to the top level.
module lkvc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lkvc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import lkvc_pkg::*;

  // The block works on one request at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // An eviction only comes from a put that missed.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[EVICT_BIT]) |-> !m_axis_tdata[HIT_BIT])
    else $error("eviction reported on a hit");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[EVICT_BIT]) |-> (m_axis_tdata[EVKEY_LSB +: KEY_W] == '0))
    else $error("evicted key not zero without eviction");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while stalled");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/lru_key_value_cache_core_tb.sv
// Testbench for the LRU key-value cache core: random and directed requests checked against a model.
`timescale 1ns / 100ps

module lru_key_value_cache_core_tb;
  import lkvc_pkg::*;

  localparam int          SLOTS      = ENTRIES_DEF;
  localparam int          PHASE_REQS = 183;
  localparam int          LONG_HOLD  = 300;
  localparam int          DRAIN_WAIT = 2 * SLOTS + 8;
  localparam int unsigned CYCLE_CAP  = 600_000;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] data;
  } cache_req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } cache_rsp_t;

  // Tracks table contents and recency, and holds the results still owed by the block.
  class lru_table_tracker;
    logic             valid [SLOTS];
    logic [KEY_W-1:0] keys  [SLOTS];
    logic [VAL_W-1:0] vals  [SLOTS];
    int unsigned      rank  [SLOTS];
    int unsigned      fill;
    logic [CAP_W-1:0] cap;
    cache_rsp_t       expected_rsp_q[$];
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] = 1'b0;
        keys[i]  = '0;
        vals[i]  = '0;
        rank[i]  = 0;
      end
      fill       = 0;
      cap        = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap = c;
    endfunction

    function int unsigned room_limit();
      if (cap == 0) return 1;
      if (cap > SLOTS) return SLOTS;
      return cap;
    endfunction

    // Make slot s the most recent; entries newer than it age by one.
    function void promote(int s);
      int unsigned r;
      r = rank[s];
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && i != s && rank[i] < r) rank[i]++;
      rank[s] = 0;
    endfunction

    function void log_request(cache_req_t r);
      cache_rsp_t e;
      int         found;
      int         slot;
      e     = '0;
      found = -1;
      slot  = -1;
      for (int i = 0; i < SLOTS; i++)
        if (found < 0 && valid[i] && keys[i] == r.key) found = i;

      if (r.kind == REQ_GET) begin
        if (found >= 0) begin
          e.hit        = 1'b1;
          e.read_value = vals[found];
          promote(found);
        end else begin
          e.read_value = MISS_VALUE;
        end
      end else if (found >= 0) begin
        e.hit       = 1'b1;
        vals[found] = r.data;
        promote(found);
      end else begin
        if (fill < room_limit())
          for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && !valid[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (valid[i]) rank[i]++;
          valid[slot] = 1'b1;
          fill++;
        end else begin
          // Replace the least recent valid entry.
          for (int i = 0; i < SLOTS; i++)
            if (valid[i] && (slot < 0 || rank[i] > rank[slot])) slot = i;
          e.evicted     = 1'b1;
          e.evicted_key = keys[slot];
          for (int i = 0; i < SLOTS; i++)
            if (valid[i] && i != slot) rank[i]++;
        end
        keys[slot] = r.key;
        vals[slot] = r.data;
        rank[slot] = 0;
      end
      expected_rsp_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(cache_rsp_t got);
      cache_rsp_t want;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_rsp_q.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
      compare_field("evicted_key", want.evicted_key, got.evicted_key);
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CAP_W-1:0]     cfg_wr_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  lru_table_tracker tracker = new();
  logic             steady;
  int unsigned      cycle_count;
  int unsigned      results_seen;
  logic [KEY_W-1:0] key_pool [24];
  int unsigned      pool_n;

  lru_key_value_cache_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic cache_req_t mk_req(logic kind, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] data);
    cache_req_t r;
    r.kind = kind;
    r.key  = key;
    r.data = data;
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    if (steady) return 0;
    return $urandom_range(0, 6);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(cache_req_t r);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.data, r.key};
    s_axis_tuser  <= r.kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.log_request(r);
    @(negedge clk);
  endtask

  // Drain all outstanding results, then write capacity while the block is idle.
  task automatic write_capacity(logic [CAP_W-1:0] c);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_capacity(c);
    @(negedge clk);
  endtask

  // Result side: random stalls, one long hold to back up the input.
  initial begin
    int unsigned wait_n;
    cache_rsp_t  got;
    m_axis_tready = 1'b0;
    results_seen  = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_n = (results_seen == 500) ? LONG_HOLD : draw_gap();
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      got.hit         = m_axis_tdata[HIT_BIT];
      got.read_value  = m_axis_tdata[VAL_LSB +: VAL_W];
      got.evicted     = m_axis_tdata[EVICT_BIT];
      got.evicted_key = m_axis_tdata[EVKEY_LSB +: KEY_W];
      tracker.check_result(got);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    logic [CAP_W-1:0] caps [10];
    logic [KEY_W-1:0] key;
    logic             kind;

    caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd16, 5'd2, 5'd5};
    cycle_count   = 0;
    steady        = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_GET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extreme keys and values, fills, evictions, hits on both kinds.
    write_capacity(5'd2);
    send_request(mk_req(REQ_GET, 32'h8000_0000, 32'h0000_0000));
    send_request(mk_req(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    send_request(mk_req(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    send_request(mk_req(REQ_GET, 32'h8000_0000, 32'h1234_5678));
    send_request(mk_req(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
    send_request(mk_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000));
    send_request(mk_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));
    send_request(mk_req(REQ_PUT, 32'h8000_0000, 32'h0000_0000));
    send_request(mk_req(REQ_PUT, 32'hFFFF_FFFF, 32'h1234_5678));
    send_request(mk_req(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF));
    send_request(mk_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000));
    send_request(mk_req(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(mk_req(REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0000));
    send_request(mk_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000));
    send_request(mk_req(REQ_GET, 32'h5555_5555, 32'hAAAA_AAAA));
    send_request(mk_req(REQ_PUT, 32'hAAAA_AAAA, 32'h5555_5555));
    send_request(mk_req(REQ_GET, 32'hAAAA_AAAA, 32'h0000_0000));
    write_capacity(5'd1);
    send_request(mk_req(REQ_PUT, 32'h0000_0001, 32'h0000_0001));
    send_request(mk_req(REQ_PUT, 32'h0000_0002, 32'h0000_0002));
    send_request(mk_req(REQ_GET, 32'h0000_0001, 32'h0000_0000));
    send_request(mk_req(REQ_GET, 32'h0000_0002, 32'h0000_0000));

    // Random phases: a key pool a little larger than the capacity keeps hits and misses mixed.
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      steady = (p % 3 == 2);
      pool_n = tracker.room_limit() + $urandom_range(1, 8);
      for (int k = 0; k < pool_n; k++) key_pool[k] = $urandom;
      for (int n = 0; n < PHASE_REQS; n++) begin
        if ($urandom_range(0, 15) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, pool_n - 1)];
        kind = $urandom_range(0, 1) ? REQ_PUT : REQ_GET;
        send_request(mk_req(kind, key, $urandom));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/lkvc_pkg.sv
rtl/core/lru_key_value_cache_core.sv
rtl/core/lkvc_checker.sv
test/lru_key_value_cache_core_tb.sv
